@@ sv/bitmap_run_length_decoder_defines.svh @@
// assertion macros for the bitmap run-length decoder
// included by the top level; no other dependencies
`ifndef BITMAP_RUN_LENGTH_DECODER_DEFINES_SVH
`define BITMAP_RUN_LENGTH_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds on every clock edge out of reset
`define BRLD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies consequence in the next cycle
`define BRLD_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`else

`define BRLD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define BRLD_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)

`endif

`endif

@@ sv/brld_pkg.sv @@
// shared types and constants of the bitmap run-length decoder
// used by brld_ctrl, brld_datapath and the top level
package brld_pkg;

    localparam int unsigned MAX_BITS_DEF = 4096;   // default run saturation limit
    localparam int unsigned GLYPH_CAP    = 4096;   // 64 words of 64 pixels
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned POS_W        = 13;     // pixel count / position width
    localparam int unsigned WORD_W       = 64;
    localparam int unsigned IDX_W        = 6;
    localparam int unsigned SENT_W       = 7;     // holds 0..64
    localparam int unsigned DATA_W       = 7;     // varint data bits per byte
    localparam int unsigned CONT_BIT     = 7;     // varint continuation flag
    localparam int unsigned VARINT_SHIFT = 7;
    localparam int unsigned DIRECT_BYTES = 3;     // bytes added before saturation rule
    localparam int unsigned CNT_W        = 3;
    localparam int unsigned CNT_MAX      = 7;
    localparam int unsigned SUM_W        = DIRECT_BYTES * VARINT_SHIFT + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    typedef struct packed {
        logic accept;       // take the input word
        logic seg_step;     // paint one segment of the current run
        logic run_done;     // close the run, flip color
        logic flush_emit;   // send one remaining word at glyph end
        logic glyph_clear;  // back to awaiting a new glyph
    } ctrl_cmd_t;

    typedef struct packed {
        logic byte_term;     // input byte ends a run
        logic in_last;       // input byte is the last of the glyph
        logic last_pend;     // accepted byte was the last
        logic run_active;    // run left and room in the bitmap
        logic seg_boundary;  // this segment completes a word
        logic flush_pending; // words still owed at glyph end
        logic out_free;      // output register can load
    } ctrl_sts_t;

endpackage

@@ sv/bitmap_run_length_decoder.sv @@
// bitmap run-length decoder, top level. Takes one byte word of a varint
// run-length stream per handshake and rebuilds a bilevel glyph bitmap as
// 64-bit words, first pixel in bit 63. Runs alternate clear and set,
// starting clear, and are clipped at the glyph size (sampled on the first
// byte, zero read as one pixel, capped at the smaller of MAX_BITS and 4096).
// A byte inside a run is only accumulated. A byte that ends a run is then
// followed by painting each word segment the run touches, then by closing
// the run; the run painter handles at most one 64-pixel word per cycle.
// After the last byte, each word still owed is sent, then the glyph is
// cleared. Every word waits on m_ready at the single output register,
// so a stalled consumer stalls the painter and intake.
// Depends on brld_pkg, brld_ctrl, brld_datapath and the defines header.
`include "bitmap_run_length_decoder_defines.svh"

module bitmap_run_length_decoder #(
    parameter int unsigned MAX_BITS = brld_pkg::MAX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // byte word input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [brld_pkg::BYTE_W-1:0]   s_code_byte,
    input  logic [brld_pkg::POS_W-1:0]    s_bitmap_bits,
    input  logic                          s_last_byte,
    // bitmap word output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [brld_pkg::IDX_W-1:0]    m_word_index,
    output logic [brld_pkg::WORD_W-1:0]   m_bitmap_word,
    output logic                          m_last_word
);
    import brld_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // state machine: idle (takes bytes), run painting, glyph flush
    brld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts_i   (sts),
        .cmd_o   (cmd)
    );

    // accumulator, painter, word buffer and output register
    brld_datapath #(
        .MAX_BITS (MAX_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_i         (cmd),
        .sts_o         (sts),
        .s_code_byte   (s_code_byte),
        .s_bitmap_bits (s_bitmap_bits),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word_index  (m_word_index),
        .m_bitmap_word (m_bitmap_word),
        .m_last_word   (m_last_word)
    );

    // painting and flushing only happen while intake is closed
    `BRLD_ASSERT_ALWAYS(a_no_work_while_ready, aclk, aresetn, !(s_ready && (cmd.seg_step || cmd.flush_emit || cmd.run_done)), "datapath work while accepting bytes")

    // a word is only pushed when the output register can take it
    `BRLD_ASSERT_ALWAYS(a_emit_into_free_slot, aclk, aresetn, !((cmd.flush_emit || (cmd.seg_step && sts.seg_boundary)) && m_valid && !m_ready), "word pushed over a held output word")

    // clearing a glyph reopens intake on the next cycle
    `BRLD_ASSERT_NEXT(a_clear_reopens, aclk, aresetn, cmd.glyph_clear, s_ready && !sts.flush_pending, "glyph clear did not return to idle")

endmodule

@@ sv/brld_ctrl.sv @@
// controller state machine of the bitmap run-length decoder
// depends on brld_pkg
module brld_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  brld_pkg::ctrl_sts_t   sts_i,
    output brld_pkg::ctrl_cmd_t   cmd_o
);
    import brld_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.accept = 1'b1;
                    if (sts_i.byte_term) begin
                        state_next = ST_RUN;
                    end else if (sts_i.in_last) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_RUN: begin
                if (sts_i.run_active) begin
                    // a segment that fills a word waits for the output register
                    cmd_o.seg_step = !sts_i.seg_boundary || sts_i.out_free;
                end else begin
                    cmd_o.run_done = 1'b1;
                    state_next     = sts_i.last_pend ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (sts_i.flush_pending) begin
                    cmd_o.flush_emit = sts_i.out_free;
                end else begin
                    cmd_o.glyph_clear = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/brld_datapath.sv @@
// datapath of the bitmap run-length decoder: varint accumulator,
// run painter, word buffer and output register; depends on brld_pkg
module brld_datapath #(
    parameter int unsigned MAX_BITS = brld_pkg::MAX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  brld_pkg::ctrl_cmd_t               cmd_i,
    output brld_pkg::ctrl_sts_t               sts_o,
    input  logic [brld_pkg::BYTE_W-1:0]       s_code_byte,
    input  logic [brld_pkg::POS_W-1:0]        s_bitmap_bits,
    input  logic                              s_last_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [brld_pkg::IDX_W-1:0]        m_word_index,
    output logic [brld_pkg::WORD_W-1:0]       m_bitmap_word,
    output logic                              m_last_word
);
    import brld_pkg::*;

    localparam int unsigned BIT_CAP = (MAX_BITS > GLYPH_CAP) ? GLYPH_CAP : MAX_BITS;
    localparam int unsigned ACC_W   = $clog2(MAX_BITS + 1);
    localparam int unsigned RNG_W   = (ACC_W > POS_W) ? ACC_W : POS_W;

    logic [POS_W-1:0]  glyph_reg, glyph_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              color_reg, color_next;
    logic [WORD_W-1:0] buf_reg, buf_next;
    logic [SENT_W-1:0] sent_reg, sent_next;
    logic              in_glyph_reg, in_glyph_next;
    logic              last_pend_reg, last_pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  m_idx_reg, m_idx_next;
    logic [WORD_W-1:0] m_word_reg, m_word_next;
    logic              m_last_reg, m_last_next;

    logic [POS_W-1:0]  glyph_eff;
    logic              byte_active;
    logic [DATA_W-1:0] data;
    logic [SUM_W-1:0]  shifted;
    logic [SUM_W-1:0]  sum;
    logic [ACC_W-1:0]  acc_add;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SENT_W-1:0] total_words;
    logic              is_last_word;

    logic [IDX_W-1:0]  off;
    logic [SENT_W-1:0] room_word;
    logic [POS_W-1:0]  room_glyph;
    logic [RNG_W-1:0]  seg_min;
    logic [SENT_W-1:0] seg_cnt;
    logic [WORD_W-1:0] seg_mask;
    logic [POS_W-1:0]  pos_step;
    logic [WORD_W-1:0] word_or;
    logic              out_free;
    logic              emit;

    // glyph size: zero counts as one pixel, clipped at the cap
    always_comb begin
        if (in_glyph_reg) begin
            glyph_eff = glyph_reg;
        end else if (s_bitmap_bits == '0) begin
            glyph_eff = POS_W'(1);
        end else if (s_bitmap_bits > POS_W'(BIT_CAP)) begin
            glyph_eff = POS_W'(BIT_CAP);
        end else begin
            glyph_eff = s_bitmap_bits;
        end
    end

    assign byte_active = pos_reg < glyph_eff;
    assign data        = s_code_byte[DATA_W-1:0];

    always_comb begin
        case (cnt_reg)
            3'd0:    shifted = SUM_W'(data);
            3'd1:    shifted = SUM_W'(data) << VARINT_SHIFT;
            3'd2:    shifted = SUM_W'(data) << (2 * VARINT_SHIFT);
            default: shifted = '0;
        endcase
    end

    assign sum = SUM_W'(acc_reg) + shifted;

    always_comb begin
        if (cnt_reg >= CNT_W'(DIRECT_BYTES)) begin
            acc_add = (data != '0) ? ACC_W'(MAX_BITS) : acc_reg;
        end else if (sum > SUM_W'(MAX_BITS)) begin
            acc_add = ACC_W'(MAX_BITS);
        end else begin
            acc_add = sum[ACC_W-1:0];
        end
    end

    assign cnt_inc = (cnt_reg == CNT_W'(CNT_MAX)) ? cnt_reg : cnt_reg + CNT_W'(1);

    assign total_words  = SENT_W'(({1'b0, glyph_reg} + (POS_W + 1)'(WORD_W - 1)) >> IDX_W);
    assign is_last_word = (sent_reg + SENT_W'(1)) == total_words;

    // one segment: up to the end of the word, the run or the bitmap
    assign off        = pos_reg[IDX_W-1:0];
    assign room_word  = SENT_W'(WORD_W) - SENT_W'(off);
    assign room_glyph = glyph_reg - pos_reg;

    always_comb begin
        seg_min = RNG_W'(room_word);
        if (RNG_W'(acc_reg) < seg_min) begin
            seg_min = RNG_W'(acc_reg);
        end
        if (RNG_W'(room_glyph) < seg_min) begin
            seg_min = RNG_W'(room_glyph);
        end
    end

    assign seg_cnt  = seg_min[SENT_W-1:0];
    assign seg_mask = ({WORD_W{1'b1}} >> off)
                    & ~({WORD_W{1'b1}} >> (SENT_W'(off) + seg_cnt));
    assign pos_step = pos_reg + POS_W'(seg_cnt);
    assign word_or  = buf_reg | (color_reg ? seg_mask : '0);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        glyph_next     = glyph_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        color_next     = color_reg;
        buf_next       = buf_reg;
        sent_next      = sent_reg;
        in_glyph_next  = in_glyph_reg;
        last_pend_next = last_pend_reg;
        m_idx_next     = m_idx_reg;
        m_word_next    = m_word_reg;
        m_last_next    = m_last_reg;
        emit           = 1'b0;

        if (cmd_i.accept) begin
            glyph_next     = glyph_eff;
            in_glyph_next  = 1'b1;
            last_pend_next = s_last_byte;
            if (byte_active) begin
                acc_next = acc_add;
                cnt_next = sts_o.byte_term ? '0 : cnt_inc;
            end
        end

        if (cmd_i.seg_step) begin
            pos_next = pos_step;
            acc_next = acc_reg - ACC_W'(seg_cnt);
            if (pos_step[IDX_W-1:0] == '0) begin
                emit        = 1'b1;
                m_word_next = word_or;
                buf_next    = '0;
            end else begin
                buf_next = word_or;
            end
        end

        if (cmd_i.run_done) begin
            color_next = !color_reg;
            acc_next   = '0;
        end

        if (cmd_i.flush_emit) begin
            emit        = 1'b1;
            m_word_next = buf_reg;
            buf_next    = '0;
        end

        if (emit) begin
            m_idx_next  = sent_reg[IDX_W-1:0];
            m_last_next = is_last_word;
            sent_next   = sent_reg + SENT_W'(1);
        end

        if (cmd_i.glyph_clear) begin
            glyph_next    = '0;
            pos_next      = '0;
            acc_next      = '0;
            cnt_next      = '0;
            color_next    = 1'b0;
            buf_next      = '0;
            sent_next     = '0;
            in_glyph_next = 1'b0;
        end

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_comb begin
        sts_o               = '0;
        sts_o.byte_term     = byte_active && (!s_code_byte[CONT_BIT] || s_last_byte);
        sts_o.in_last       = s_last_byte;
        sts_o.last_pend     = last_pend_reg;
        sts_o.run_active    = (acc_reg != '0) && (pos_reg < glyph_reg);
        sts_o.seg_boundary  = pos_step[IDX_W-1:0] == '0;
        sts_o.flush_pending = sent_reg < total_words;
        sts_o.out_free      = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_reg     <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            color_reg     <= 1'b0;
            buf_reg       <= '0;
            sent_reg      <= '0;
            in_glyph_reg  <= 1'b0;
            last_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            glyph_reg     <= glyph_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            color_reg     <= color_next;
            buf_reg       <= buf_next;
            sent_reg      <= sent_next;
            in_glyph_reg  <= in_glyph_next;
            last_pend_reg <= last_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_idx_reg  <= m_idx_next;
        m_word_reg <= m_word_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_word_index  = m_idx_reg;
    assign m_bitmap_word = m_word_reg;
    assign m_last_word   = m_last_reg;

endmodule

@@ bench/testbench.sv @@
// self-checking bench for bitmap_run_length_decoder: directed table, then random glyph streams
// predicted words come from a bit-exact decoder model held in this file
// depends on brld_pkg and the decoder rtl only
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import brld_pkg::*;

    // run limit of the accumulator, passed to the block so both sides agree
    localparam int unsigned SAT_LIMIT = MAX_BITS_DEF;
    // largest glyph: the smaller of the run limit and 64 full words
    localparam int unsigned PIXEL_CAP = (SAT_LIMIT < GLYPH_CAP) ? SAT_LIMIT : GLYPH_CAP;
    localparam logic [7:0]  DATA_MASK = 8'h7f;
    localparam logic [7:0]  CONT_FLAG = 8'h80;
    localparam int unsigned WORD_PIX  = 64;
    localparam int unsigned PHASE_BYTES = 125;
    localparam int unsigned DRAIN_CYCLES = 200;

    // one input word: byte, glyph size, last flag, and an optional typed-in answer
    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic [POS_W-1:0]  px;
        logic              last;
        logic              typed;
        logic [WORD_W-1:0] typed_word;
    } code_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] bitmap_word;
        logic              last_word;
    } bitmap_out_t;

    // clock, reset and block inputs, all known from time zero
    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_code_byte = '0;
    logic [POS_W-1:0]  s_bitmap_bits = '0;
    logic              s_last_byte = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [IDX_W-1:0]  m_word_index;
    logic [WORD_W-1:0] m_bitmap_word;
    logic              m_last_word;

    // typed answer travels beside the payload so the scoreboard sees it at acceptance
    logic              drv_typed = 1'b0;
    logic [WORD_W-1:0] drv_typed_word = '0;

    // idle percentages of the current phase
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;

    // bookkeeping
    code_item_t  byte_feed[$];
    bitmap_out_t expected_words[$];
    int unsigned mismatches = 0;
    int unsigned bytes_taken = 0;
    int unsigned glyphs_done = 0;
    int unsigned words_seen = 0;
    int unsigned full_glyphs = 0;

    // decoder model state
    int unsigned px_pos;
    int unsigned run_len;
    int unsigned vbytes;
    logic        color_set;
    logic [WORD_W-1:0] word_acc;
    int unsigned n_sent;
    int unsigned glyph_size;
    logic        glyph_open = 1'b0;

    // directed table: extremes and every special case of the decoder
    code_item_t directed_rows [0:22] = '{
        // first word after reset, zero size read as one pixel, zero-length clear run
        '{8'h00, 13'd0,    1'b1, 1'b1, 64'h0},
        // one full word of set pixels after an empty clear run
        '{8'h00, 13'd64,   1'b0, 1'b0, 64'h0},
        '{8'h40, 13'd64,   1'b1, 1'b1, 64'hffff_ffff_ffff_ffff},
        // oversize glyph clipped to 64 words, three-byte run saturating, then ignored last byte
        '{8'h00, 13'd8191, 1'b0, 1'b0, 64'h0},
        '{8'hff, 13'd8191, 1'b0, 1'b0, 64'h0},
        '{8'hff, 13'd8191, 1'b0, 1'b0, 64'h0},
        '{8'h7f, 13'd8191, 1'b0, 1'b0, 64'h0},
        '{8'h00, 13'd8191, 1'b1, 1'b0, 64'h0},
        // long varint: data past 21 bits saturates, byte count pins at its top
        '{8'h00, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h85, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h80, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h80, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h81, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h80, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h80, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h80, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h80, 13'd200,  1'b0, 1'b0, 64'h0},
        '{8'h00, 13'd200,  1'b0, 1'b0, 64'h0},
        // bitmap full, byte ignored, partial word flushed
        '{8'h12, 13'd200,  1'b1, 1'b0, 64'h0},
        // unfinished varint at the last byte still paints its three pixels
        '{8'h00, 13'd64,   1'b0, 1'b0, 64'h0},
        '{8'h83, 13'd64,   1'b1, 1'b1, 64'he000_0000_0000_0000},
        // single-pixel glyph, run clipped at the bitmap size
        '{8'h00, 13'd1,    1'b0, 1'b0, 64'h0},
        '{8'h05, 13'd1,    1'b1, 1'b1, 64'h8000_0000_0000_0000}
    };

    bitmap_run_length_decoder #(
        .MAX_BITS(SAT_LIMIT)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_code_byte   (s_code_byte),
        .s_bitmap_bits (s_bitmap_bits),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word_index  (m_word_index),
        .m_bitmap_word (m_bitmap_word),
        .m_last_word   (m_last_word)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver stalls at the phase's rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // one line per mismatch, counted
    task automatic flag_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // close out the word under construction as the next expected bitmap word
    function automatic void emit_expected_word();
        bitmap_out_t w;
        w.word_index  = n_sent[IDX_W-1:0];
        w.bitmap_word = word_acc;
        w.last_word   = (n_sent + 1 == (glyph_size + WORD_PIX - 1) / WORD_PIX);
        expected_words.insert(expected_words.size(), w);
        n_sent++;
        word_acc = '0;
    endfunction

    // decode one accepted byte: varint accumulate, paint finished runs, flush at glyph end
    function automatic void decode_code_byte(input logic [BYTE_W-1:0] code,
                                             input logic [POS_W-1:0] px_req,
                                             input logic is_last);
        int unsigned data;
        int unsigned sum;
        int unsigned run;
        int unsigned off;
        int unsigned seg;
        logic [WORD_W-1:0] mask;
        // size is taken from the first byte of a glyph only
        if (!glyph_open) begin
            glyph_size = (px_req == 0) ? 1 : 32'(px_req);
            if (glyph_size > PIXEL_CAP)
                glyph_size = PIXEL_CAP;
            px_pos = 0;
            run_len = 0;
            vbytes = 0;
            color_set = 1'b0;
            word_acc = '0;
            n_sent = 0;
            glyph_open = 1'b1;
        end
        // once the bitmap is full, bytes are dropped
        if (px_pos < glyph_size) begin
            data = 32'(code & DATA_MASK);
            if (vbytes >= DIRECT_BYTES) begin
                // any data this deep is beyond the limit
                if (data != 0)
                    run_len = SAT_LIMIT;
            end else begin
                sum = run_len + (data << (VARINT_SHIFT * vbytes));
                run_len = (sum > SAT_LIMIT) ? SAT_LIMIT : sum;
            end
            if (vbytes < CNT_MAX)
                vbytes++;
            // run ends on a clear continuation flag, or unfinished at the last byte
            if (!code[CONT_BIT] || is_last) begin
                run = run_len;
                while (run > 0 && px_pos < glyph_size) begin
                    off = px_pos % WORD_PIX;
                    seg = WORD_PIX - off;
                    if (seg > run)
                        seg = run;
                    if (seg > glyph_size - px_pos)
                        seg = glyph_size - px_pos;
                    if (color_set) begin
                        mask = (seg >= WORD_PIX) ? '1
                             : (((64'd1 << seg) - 64'd1) << (WORD_PIX - off - seg));
                        word_acc |= mask;
                    end
                    px_pos += seg;
                    run -= seg;
                    if (px_pos % WORD_PIX == 0)
                        emit_expected_word();
                end
                color_set = !color_set;
                run_len = 0;
                vbytes = 0;
            end
        end
        // every glyph ends with all of its words, zero where untouched
        if (is_last) begin
            if (glyph_size == PIXEL_CAP)
                full_glyphs++;
            while (n_sent < (glyph_size + WORD_PIX - 1) / WORD_PIX)
                emit_expected_word();
            glyph_open = 1'b0;
        end
    endfunction

    // scoreboard: predict on each accepted byte, then check each accepted bitmap word
    always @(posedge aclk) begin : scoreboard
        bitmap_out_t seen;
        bitmap_out_t want;
        int unsigned mark;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                mark = expected_words.size();
                decode_code_byte(s_code_byte, s_bitmap_bits, s_last_byte);
                // typed-in rows replace the model's answer with the hand-written one
                if (drv_typed) begin
                    while (expected_words.size() > mark)
                        void'(expected_words.pop_back());
                    want.word_index  = '0;
                    want.bitmap_word = drv_typed_word;
                    want.last_word   = 1'b1;
                    expected_words.insert(expected_words.size(), want);
                end
                bytes_taken++;
                if (s_last_byte)
                    glyphs_done++;
            end
            if (m_valid && m_ready) begin
                seen.word_index  = m_word_index;
                seen.bitmap_word = m_bitmap_word;
                seen.last_word   = m_last_word;
                words_seen++;
                if (expected_words.size() == 0) begin
                    flag_mismatch($sformatf("word with nothing expected, index %0d data %h",
                                            seen.word_index, seen.bitmap_word));
                end else begin
                    want = expected_words.pop_front();
                    if (seen.word_index !== want.word_index)
                        flag_mismatch($sformatf("word_index got %0d want %0d",
                                                seen.word_index, want.word_index));
                    if (seen.bitmap_word !== want.bitmap_word)
                        flag_mismatch($sformatf("bitmap_word %0d got %h want %h",
                                                want.word_index, seen.bitmap_word,
                                                want.bitmap_word));
                    if (seen.last_word !== want.last_word)
                        flag_mismatch($sformatf("last_word %0d got %b want %b",
                                                want.word_index, seen.last_word,
                                                want.last_word));
                end
            end
        end
    end

    // queue one plain byte of the current glyph
    function automatic void add_code(input logic [BYTE_W-1:0] code, input logic [POS_W-1:0] px);
        code_item_t it;
        it.code = code;
        it.px = px;
        it.last = 1'b0;
        it.typed = 1'b0;
        it.typed_word = '0;
        byte_feed.insert(byte_feed.size(), it);
    endfunction

    // one well-formed glyph: varint runs with random content, sometimes ragged at the end
    function automatic void queue_glyph();
        int unsigned px;
        int unsigned eff;
        int unsigned nruns;
        int unsigned run;
        int unsigned pick;
        int unsigned pads;
        logic [POS_W-1:0] px_bits;
        // mostly small glyphs, a few near or past the largest size
        pick = $urandom_range(99);
        if (pick < 4)
            px = 0;
        else if (pick < 8)
            px = $urandom_range(8191, PIXEL_CAP + 1);
        else if (pick < 14)
            px = $urandom_range(PIXEL_CAP, PIXEL_CAP / 2);
        else
            px = $urandom_range(300, 1);
        px_bits = POS_W'(px);
        eff = (px == 0) ? 1 : ((px > PIXEL_CAP) ? PIXEL_CAP : px);
        nruns = $urandom_range(12, 1);
        for (int r = 0; r < nruns; r++) begin
            case ($urandom_range(9))
                0: run = 0;
                1: run = $urandom_range(20000, 128);
                2: run = $urandom_range(32'h0fff_ffff, 32'h0020_0000);
                default: run = $urandom_range(eff / 3 + 4, 1);
            endcase
            while (run > 127) begin
                add_code(CONT_FLAG | run[7:0], px_bits);
                run = run >> VARINT_SHIFT;
            end
            // occasionally a padded varint with zero bytes after the data
            if ($urandom_range(9) == 0) begin
                add_code(CONT_FLAG | run[7:0], px_bits);
                pads = $urandom_range(5, 1);
                for (int p = 1; p < pads; p++)
                    add_code(CONT_FLAG, px_bits);
                add_code(8'h00, px_bits);
            end else begin
                add_code(run[7:0], px_bits);
            end
        end
        case ($urandom_range(9))
            // unfinished varint at the last byte
            0: byte_feed[$].code[CONT_BIT] = 1'b1;
            // trailing bytes after the runs
            1: begin
                pads = $urandom_range(3, 1);
                for (int p = 0; p < pads; p++)
                    add_code(BYTE_W'($urandom_range(255)), px_bits);
            end
            default: ;
        endcase
        byte_feed[$].last = 1'b1;
    endfunction

    // noise: a short glyph of arbitrary bytes and sizes
    function automatic void queue_noise();
        int unsigned n;
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++)
            add_code(BYTE_W'($urandom_range(255)), POS_W'($urandom_range(8191)));
        byte_feed[$].last = 1'b1;
    endfunction

    // fill one phase's worth of random stimulus
    function automatic void queue_random_phase();
        int unsigned start;
        start = byte_feed.size();
        while (byte_feed.size() - start < PHASE_BYTES) begin
            if ($urandom_range(9) == 0)
                queue_noise();
            else
                queue_glyph();
        end
    endfunction

    // drive queued words; valid stays high across back-to-back words
    task automatic send_feed();
        code_item_t it;
        while (byte_feed.size() != 0) begin
            it = byte_feed.pop_front();
            while ($urandom_range(99) < src_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid        <= 1'b1;
            s_code_byte    <= it.code;
            s_bitmap_bits  <= it.px;
            s_last_byte    <= it.last;
            drv_typed      <= it.typed;
            drv_typed_word <= it.typed_word;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
        end
    endtask

    // main sequence
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table with no idling
        foreach (directed_rows[i])
            byte_feed.insert(byte_feed.size(), directed_rows[i]);
        send_feed();

        // random phases: free flow, slow sender, slow receiver, both
        queue_random_phase();
        send_feed();

        src_idle_pct = 77;
        queue_random_phase();
        send_feed();

        src_idle_pct = 0;
        sink_stall_pct = 77;
        queue_random_phase();
        send_feed();

        src_idle_pct = 23;
        sink_stall_pct = 23;
        queue_random_phase();
        send_feed();

        s_valid <= 1'b0;
        @(posedge aclk);

        // drain, then give the block time to show any stray word
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d code bytes in %0d glyphs, %0d of them at the full size",
                 bytes_taken, glyphs_done, full_glyphs);
        $display("compared %0d bitmap words, %0d mismatches", words_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout with %0d words still expected", expected_words.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
